>>> src/calendar_date_to_epoch_seconds_macros.svh
// ============================================================================
// calendar_date_to_epoch_seconds_macros
// Assertion helpers shared by the year and scale stages of the date-to-epoch pipeline.
// ============================================================================
`ifndef CALENDAR_DATE_TO_EPOCH_SECONDS_MACROS_SVH
`define CALENDAR_DATE_TO_EPOCH_SECONDS_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cde_pkg.sv
// ============================================================================
// cde_pkg
// Shared constants, beat types and the month table of the date-to-epoch pipe.
// ============================================================================
package cde_pkg;

    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int EPOCH_W   = 36;

    // day counts and seconds of day
    localparam int DAYS_W    = 20;
    localparam int LEAPS_W   = 10;
    localparam int DBM_W     = 9;
    localparam int TOD_W     = 17;

    localparam logic [YEAR_W-1:0] CENTURY_BASE = 12'd2000;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd1970;

    // leap years in 1..1969
    localparam logic [LEAPS_W:0] LEAPS_BEFORE_EPOCH = 11'd477;

    // n / 100 == (n * 5243) >> 19 for every n below 43690
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PROD_W = 25;
    localparam int Q100_W = DIV100_PROD_W - DIV100_SHIFT;
    localparam logic [DIV100_PROD_W-1:0] DIV100_MUL = 25'd5243;

    localparam logic [EPOCH_W-1:0] SECS_PER_DAY = 36'd86400;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // beat leaving the year stages
    typedef struct packed {
        logic [DAYS_W-1:0]  yr_days;
        logic [LEAPS_W-1:0] leaps;
        logic               leap;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [TOD_W-1:0]   tod;
    } t_yr_beat;

    // beat leaving the day accumulator
    typedef struct packed {
        logic [DAYS_W-1:0] days_m1;
        logic [TOD_W-1:0]  tod;
    } t_day_beat;

    // days in a common year before the first of the month
    function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [DBM_W-1:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> src/cde_year.sv
// ============================================================================
// cde_year
// Two stages: year folding, month clamp and time of day, then the divide by
// 100 by reciprocal, the leap test and the days of whole years since 1970.
// ============================================================================
`include "calendar_date_to_epoch_seconds_macros.svh"

module cde_year (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [cde_pkg::YEAR_W-1:0]   i_year,
    input  logic [cde_pkg::MONTH_W-1:0]  i_month,
    input  logic [cde_pkg::DAY_W-1:0]    i_day,
    input  logic [cde_pkg::HOUR_W-1:0]   i_hour,
    input  logic [cde_pkg::MINUTE_W-1:0] i_minute,
    input  logic [cde_pkg::SECOND_W-1:0] i_second,
    output logic                         o_valid,
    output cde_pkg::t_yr_beat            o_beat
);
    import cde_pkg::*;

    // stage 1 registers
    logic                     r_v1;
    logic [YEAR_W-1:0]        r_year;
    logic [MONTH_W-1:0]       r_month;
    logic [DAY_W-1:0]         r_day;
    logic [TOD_W-1:0]         r_tod;
    logic [DIV100_PROD_W-1:0] r_prod_y;
    logic [DIV100_PROD_W-1:0] r_prod_m1;

    logic [YEAR_W-1:0]        n_year;
    logic [MONTH_W-1:0]       n_month;
    logic [TOD_W-1:0]         n_tod;
    logic [DIV100_PROD_W-1:0] n_prod_y;
    logic [DIV100_PROD_W-1:0] n_prod_m1;

    // stage 2 registers
    logic     r_v2;
    t_yr_beat r_beat;
    t_yr_beat n_beat;

    logic [Q100_W-1:0]  w_q_y;
    logic [Q100_W-1:0]  w_q_m1;
    logic [YEAR_W-1:0]  w_ym1;
    logic [YEAR_W-1:0]  w_rem100;
    logic [LEAPS_W:0]   w_leaps;

    // fold years below 2000, clamp month, reciprocal products, time of day
    always_comb begin
        n_year = (i_year < CENTURY_BASE) ? i_year + CENTURY_BASE : i_year;
        if (i_month < MONTH_JAN) begin
            n_month = MONTH_JAN;
        end else if (i_month > MONTH_DEC) begin
            n_month = MONTH_DEC;
        end else begin
            n_month = i_month;
        end
        n_prod_y  = DIV100_PROD_W'(n_year) * DIV100_MUL;
        n_prod_m1 = DIV100_PROD_W'(n_year - 12'd1) * DIV100_MUL;
        n_tod     = TOD_W'(i_hour) * 17'd3600 + TOD_W'(i_minute) * 17'd60
                  + TOD_W'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_year    <= n_year;
        r_month   <= n_month;
        r_day     <= i_day;
        r_tod     <= n_tod;
        r_prod_y  <= n_prod_y;
        r_prod_m1 <= n_prod_m1;
    end

    // quotients by 100, leap test, leap count and whole-year days
    always_comb begin
        w_q_y    = r_prod_y[DIV100_SHIFT +: Q100_W];
        w_q_m1   = r_prod_m1[DIV100_SHIFT +: Q100_W];
        w_ym1    = r_year - 12'd1;
        w_rem100 = r_year - YEAR_W'(w_q_y) * 12'd100;
        w_leaps  = (LEAPS_W+1)'(w_ym1[YEAR_W-1:2]) - (LEAPS_W+1)'(w_q_m1)
                 + (LEAPS_W+1)'(w_q_m1[Q100_W-1:2]) - LEAPS_BEFORE_EPOCH;

        n_beat.yr_days = DAYS_W'(r_year - EPOCH_YEAR) * 20'd365;
        n_beat.leaps   = w_leaps[LEAPS_W-1:0];
        n_beat.leap    = ((r_year[1:0] == 2'd0) && (w_rem100 != 12'd0))
                      || ((w_rem100 == 12'd0) && (w_q_y[1:0] == 2'd0));
        n_beat.month   = r_month;
        n_beat.day     = r_day;
        n_beat.tod     = r_tod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_beat <= n_beat;
    end

    assign o_valid = r_v2;
    assign o_beat  = r_beat;

    // folded year stays in the 2000 onward range
    `CDE_ASSERT_NOW(a_year_folded, i_clk, i_rst_n, r_v1, r_year >= CENTURY_BASE, "year not folded")
    // clamped month lies in January..December
    `CDE_ASSERT_NOW(a_month_clamped, i_clk, i_rst_n, r_v1, (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC), "month out of range")
    // a beat in stage 1 moves on to stage 2
    `CDE_ASSERT_NEXT(a_v1_to_v2, i_clk, i_rst_n, r_v1, r_v2, "stage 1 beat lost")

endmodule

>>> src/cde_accum.sv
// ============================================================================
// cde_accum
// One stage: sums whole-year days, leap days, whole-month days and the day of
// the month into a zero-based day count.
// ============================================================================
module cde_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cde_pkg::t_yr_beat i_beat,
    output logic              o_valid,
    output cde_pkg::t_day_beat o_beat
);
    import cde_pkg::*;

    logic      r_v3;
    t_day_beat r_beat;
    t_day_beat n_beat;
    logic      w_extra;

    // leap day counts only once February is past
    always_comb begin
        w_extra        = i_beat.leap && (i_beat.month > MONTH_FEB);
        n_beat.days_m1 = i_beat.yr_days + DAYS_W'(i_beat.leaps)
                       + DAYS_W'(days_before(i_beat.month)) + DAYS_W'(w_extra)
                       + DAYS_W'(i_beat.day) - 20'd1;
        n_beat.tod     = i_beat.tod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
        end
        r_beat <= n_beat;
    end

    assign o_valid = r_v3;
    assign o_beat  = r_beat;

endmodule

>>> src/cde_scale.sv
// ============================================================================
// cde_scale
// Two stages: day count times seconds per day, then the time of day added
// into the result register.
// ============================================================================
`include "calendar_date_to_epoch_seconds_macros.svh"

module cde_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cde_pkg::t_day_beat          i_beat,
    output logic                        o_done,
    output logic [cde_pkg::EPOCH_W-1:0] o_epoch
);
    import cde_pkg::*;

    logic               r_v4;
    logic [EPOCH_W-1:0] r_prod;
    logic [TOD_W-1:0]   r_tod;
    logic [EPOCH_W-1:0] n_prod;

    logic               r_v5;
    logic [EPOCH_W-1:0] r_epoch;
    logic [EPOCH_W-1:0] n_epoch;

    // seconds of the whole days
    assign n_prod = EPOCH_W'(i_beat.days_m1) * SECS_PER_DAY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
        end
        r_prod <= n_prod;
        r_tod  <= i_beat.tod;
    end

    // add the time of day
    assign n_epoch = r_prod + EPOCH_W'(r_tod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_epoch <= n_epoch;
    end

    assign o_done  = r_v5;
    assign o_epoch = r_epoch;

    // a product beat always comes out as a result the next cycle
    `CDE_ASSERT_NEXT(a_v4_to_done, i_clk, i_rst_n, r_v4, r_v5, "product beat lost")
    // no result appears without a product beat before it
    `CDE_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !r_v4, !r_v5, "spurious result beat")

endmodule

>>> src/calendar_date_to_epoch_seconds.sv
// Pipeline: the accepting edge loads the first of five register stages; the result strobe
// rises once the beat has passed through all five, r_v1 to r_v5 in that order.
// Throughput: one beat per cycle; the five register stages all advance every cycle.
// busy is always low, since results cannot be held off and nothing ever stalls.
// Reset (synchronous, active low) clears every stage valid bit; no beat is in flight after it.
// ============================================================================
// calendar_date_to_epoch_seconds
// Calendar date and time of day to seconds since 1970-01-01 00:00:00 UTC.
// ============================================================================
module calendar_date_to_epoch_seconds (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cde_pkg::YEAR_W-1:0]   i_year_in,
    input  logic [cde_pkg::MONTH_W-1:0]  i_month_in,
    input  logic [cde_pkg::DAY_W-1:0]    i_day_in,
    input  logic [cde_pkg::HOUR_W-1:0]   i_hour_in,
    input  logic [cde_pkg::MINUTE_W-1:0] i_minute_in,
    input  logic [cde_pkg::SECOND_W-1:0] i_second_in,
    output logic                         o_done,
    output logic [cde_pkg::EPOCH_W-1:0]  o_epoch_seconds
);
    import cde_pkg::*;

    logic      w_yr_valid;
    t_yr_beat  w_yr_beat;
    logic      w_day_valid;
    t_day_beat w_day_beat;
    logic      w_accept;

    // the pipe never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // year, leap and whole-year days
    cde_year u_year (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_year   (i_year_in),
        .i_month  (i_month_in),
        .i_day    (i_day_in),
        .i_hour   (i_hour_in),
        .i_minute (i_minute_in),
        .i_second (i_second_in),
        .o_valid  (w_yr_valid),
        .o_beat   (w_yr_beat)
    );

    // total day count
    cde_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_yr_valid),
        .i_beat  (w_yr_beat),
        .o_valid (w_day_valid),
        .o_beat  (w_day_beat)
    );

    // scale to seconds and add time of day
    cde_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_day_valid),
        .i_beat  (w_day_beat),
        .o_done  (o_done),
        .o_epoch (o_epoch_seconds)
    );

endmodule

>>> bench/epoch_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// epoch_checker
// Watches the date and result channels of the date-to-epoch block, works out
// the seconds count of every accepted date beat on its own and compares each
// result strobe, in order, against the oldest outstanding prediction.
// ============================================================================
module epoch_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [cde_pkg::YEAR_W-1:0]   year,
    input  logic [cde_pkg::MONTH_W-1:0]  month,
    input  logic [cde_pkg::DAY_W-1:0]    day,
    input  logic [cde_pkg::HOUR_W-1:0]   hour,
    input  logic [cde_pkg::MINUTE_W-1:0] minute,
    input  logic [cde_pkg::SECOND_W-1:0] second,
    input  logic                         o_done,
    input  logic [cde_pkg::EPOCH_W-1:0]  o_epoch_seconds,
    output int                           mismatch_count,
    output int                           outstanding,
    output int                           checked_count
);
    import cde_pkg::*;

    // one accepted date beat and the seconds count it should give
    typedef struct {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [EPOCH_W-1:0]  secs;
    } t_date_beat;

    t_date_beat pending_dates[$];
    int         n_bad  = 0;
    int         n_seen = 0;

    assign mismatch_count = n_bad;
    assign checked_count  = n_seen;

    // leap years in 1..n under the gregorian rule
    function automatic longint unsigned leap_years_upto(input longint unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // seconds from 1970-01-01 00:00:00 to the given date and time of day
    function automatic logic [EPOCH_W-1:0] unix_seconds(
        input logic [YEAR_W-1:0]   yr,
        input logic [MONTH_W-1:0]  mon,
        input logic [DAY_W-1:0]    dy,
        input logic [HOUR_W-1:0]   hr,
        input logic [MINUTE_W-1:0] mi,
        input logic [SECOND_W-1:0] se
    );
        longint unsigned y;
        longint unsigned m;
        longint unsigned days;
        longint unsigned total;
        bit              is_leap;
        y = yr;
        // years below 2000 land in 2000-3999, so two-digit years land in 2000-2099
        if (y < 2000) y = y + 2000;
        days = 365 * (y - 1970) + leap_years_upto(y - 1) - leap_years_upto(1969);
        // month zero counts as january, anything past twelve as december
        m = mon;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        case (m)
            2:       days = days + 31;
            3:       days = days + 59;
            4:       days = days + 90;
            5:       days = days + 120;
            6:       days = days + 151;
            7:       days = days + 181;
            8:       days = days + 212;
            9:       days = days + 243;
            10:      days = days + 273;
            11:      days = days + 304;
            12:      days = days + 334;
            default: days = days;
        endcase
        is_leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m > 2 && is_leap) days = days + 1;
        // day is counted from one, so day zero drops a whole day
        days  = days + dy;
        total = days * 86400 - 86400 + longint'(hr) * 3600 + longint'(mi) * 60 + se;
        return total[EPOCH_W-1:0];
    endfunction

    // compare result beats, then record newly accepted date beats
    always @(posedge i_clk) begin
        t_date_beat beat;
        if (i_rst_n) begin
            if (o_done) begin
                n_seen = n_seen + 1;
                if (pending_dates.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("mismatch: result %0d with no date outstanding",
                                 o_epoch_seconds);
                end else begin
                    beat = pending_dates.pop_front();
                    if (o_epoch_seconds !== beat.secs) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10)
                            $display("mismatch: %0d-%0d-%0d %0d:%0d:%0d expected %0d got %0d",
                                     beat.year, beat.month, beat.day, beat.hour,
                                     beat.minute, beat.second, beat.secs,
                                     o_epoch_seconds);
                    end
                end
            end
            if (start && !busy) begin
                beat.year   = year;
                beat.month  = month;
                beat.day    = day;
                beat.hour   = hour;
                beat.minute = minute;
                beat.second = second;
                beat.secs   = unix_seconds(year, month, day, hour, minute, second);
                pending_dates.push_back(beat);
            end
        end
        outstanding <= pending_dates.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench of the date-to-epoch block: drives directed edge dates and then
// random dates under three sender idle mixes, while epoch_checker predicts
// and compares every result beat; gives the verdict at the end.
// ============================================================================
module tb;
    import cde_pkg::*;

    localparam int PIPE_DRAIN   = 12;
    localparam int PHASE_BEATS  = 375;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    logic [YEAR_W-1:0]   year_d    = '0;
    logic [MONTH_W-1:0]  month_d   = '0;
    logic [DAY_W-1:0]    day_d     = '0;
    logic [HOUR_W-1:0]   hour_d    = '0;
    logic [MINUTE_W-1:0] minute_d  = '0;
    logic [SECOND_W-1:0] second_d  = '0;
    logic                o_done;
    logic [EPOCH_W-1:0]  o_epoch_seconds;

    int mismatch_count;
    int outstanding;
    int checked_count;
    int dates_sent = 0;
    int idle_pct   = 0;

    calendar_date_to_epoch_seconds u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_year_in       (year_d),
        .i_month_in      (month_d),
        .i_day_in        (day_d),
        .i_hour_in       (hour_d),
        .i_minute_in     (minute_d),
        .i_second_in     (second_d),
        .o_done          (o_done),
        .o_epoch_seconds (o_epoch_seconds)
    );

    epoch_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .year            (year_d),
        .month           (month_d),
        .day             (day_d),
        .hour            (hour_d),
        .minute          (minute_d),
        .second          (second_d),
        .o_done          (o_done),
        .o_epoch_seconds (o_epoch_seconds),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .checked_count   (checked_count)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // one date beat: optional idle gap, then hold start until taken
    task automatic send_date(
        input logic [YEAR_W-1:0]   yr,
        input logic [MONTH_W-1:0]  mon,
        input logic [DAY_W-1:0]    dy,
        input logic [HOUR_W-1:0]   hr,
        input logic [MINUTE_W-1:0] mi,
        input logic [SECOND_W-1:0] se
    );
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        year_d   <= yr;
        month_d  <= mon;
        day_d    <= dy;
        hour_d   <= hr;
        minute_d <= mi;
        second_d <= se;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        dates_sent = dates_sent + 1;
    endtask

    // random date, mostly in range, with leap, century and raw-width picks
    task automatic send_random_date();
        logic [YEAR_W-1:0]   yr;
        logic [MONTH_W-1:0]  mon;
        logic [DAY_W-1:0]    dy;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mi;
        logic [SECOND_W-1:0] se;
        case ($urandom_range(9))
            0, 1:    yr = YEAR_W'($urandom);
            2:       yr = YEAR_W'($urandom_range(99));
            3:       yr = YEAR_W'(100 * $urandom_range(20, 40));
            4:       yr = YEAR_W'(4 * $urandom_range(500, 1023));
            default: yr = YEAR_W'($urandom_range(2000, 4095));
        endcase
        mon = ($urandom_range(9) < 8) ? MONTH_W'($urandom_range(1, 12)) : MONTH_W'($urandom);
        dy  = ($urandom_range(9) < 8) ? DAY_W'($urandom_range(1, 31)) : DAY_W'($urandom);
        hr  = ($urandom_range(9) < 8) ? HOUR_W'($urandom_range(23)) : HOUR_W'($urandom);
        mi  = ($urandom_range(9) < 8) ? MINUTE_W'($urandom_range(59)) : MINUTE_W'($urandom);
        se  = ($urandom_range(9) < 8) ? SECOND_W'($urandom_range(60)) : SECOND_W'($urandom);
        send_date(yr, mon, dy, hr, mi, se);
    endtask

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edge dates, back to back
        idle_pct = 0;
        send_date(12'd2000, MONTH_JAN, 5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd0,    MONTH_JAN, 5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd1999, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(12'd4095, MONTH_DEC, 5'd31, 5'd31, 6'd63, 6'd63);
        send_date(12'd4095, 4'd15,     5'd31, 5'd31, 6'd63, 6'd63);
        send_date(12'd2024, MONTH_FEB, 5'd29, 5'd12, 6'd30, 6'd60);
        send_date(12'd2024, 4'd3,      5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd2023, 4'd3,      5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd2100, 4'd3,      5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd2400, 4'd3,      5'd1,  5'd0,  6'd0,  6'd0);
        send_date(12'd2100, MONTH_FEB, 5'd29, 5'd0,  6'd0,  6'd0);
        send_date(12'd2400, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd60);
        send_date(12'd2025, 4'd0,      5'd15, 5'd6,  6'd7,  6'd8);
        send_date(12'd2025, 4'd13,     5'd15, 5'd6,  6'd7,  6'd8);
        send_date(12'd2025, MONTH_JAN, 5'd0,  5'd0,  6'd0,  6'd0);
        send_date(12'd2000, MONTH_JAN, 5'd0,  5'd0,  6'd0,  6'd0);
        send_date(12'd2025, MONTH_FEB, 5'd31, 5'd0,  6'd0,  6'd0);
        send_date(12'd2025, 4'd4,      5'd31, 5'd24, 6'd60, 6'd61);
        send_date(12'd1970, 4'd6,      5'd15, 5'd10, 6'd20, 6'd30);
        send_date(12'd99,   4'd11,     5'd30, 5'd1,  6'd2,  6'd3);
        send_date(12'd3999, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(12'd2048, 4'd10,     5'd21, 5'd16, 6'd42, 6'd21);
        send_date(12'd2730, 4'd5,      5'd10, 5'd21, 6'd21, 6'd42);

        // random dates under three sender idle mixes
        idle_pct = 15;
        repeat (PHASE_BEATS) send_random_date();
        idle_pct = 48;
        repeat (PHASE_BEATS) send_random_date();
        idle_pct = 0;
        repeat (PHASE_BEATS) send_random_date();
        start <= 1'b0;

        // drain the pipe
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);

        $display("covered %0d date beats (edge dates, then random dates at 15%%, 48%% and no idle)",
                 dates_sent);
        $display("%0d results compared, %0d mismatches, %0d left outstanding",
                 checked_count, mismatch_count, outstanding);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
